>>> hw/rtl/dedup_vertex_refcount_allocator_unit_assert.svh
// Assertion macros for the dedup allocator.
// Included by the top level; no other dependencies.
`ifndef DEDUP_VERTEX_REFCOUNT_ALLOCATOR_UNIT_ASSERT_SVH
`define DEDUP_VERTEX_REFCOUNT_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DVA_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DVA_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define DVA_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define DVA_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

>>> hw/rtl/dva_pkg.sv
// Shared types and constants for the dedup vertex allocator.
// No dependencies.
package dva_pkg;
    localparam int TriDepthDef  = 256;
    localparam int VertDepthDef = 256;
    localparam int MaxRefsDef   = 255;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRI_FULL  = 3'd1;
    localparam logic [2:0] ST_VERT_FULL = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  remove_index;
        logic [31:0] a_x;
        logic [31:0] a_y;
        logic [31:0] a_z;
        logic [31:0] b_x;
        logic [31:0] b_y;
        logic [31:0] b_z;
        logic [31:0] c_x;
        logic [31:0] c_y;
        logic [31:0] c_z;
    } dva_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] tri_slot;
        logic [7:0] slot_a;
        logic [7:0] slot_b;
        logic [7:0] slot_c;
    } dva_out_t;
endpackage

>>> hw/rtl/dva_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/dedup_vertex_refcount_allocator_unit.sv
// Channel   Ports          Handshake      Payload
// input     s_valid/ready  valid & ready  dva_in_t s_data
// result    m_valid/ready  valid & ready  dva_out_t m_data
// An add scans the key memory for each corner that is not a repeat, slot by slot
// (read, then compare), stopping at the first match. After reset a pass over
// all VERT_DEPTH slots clears the live/ref memory; no item is taken meanwhile.
// A result waits in the output register while the next item is processed; a
// second finished result holds the machine, and the input, until it drains.
// Depends on dva_pkg, dva_ram and the assertion header.
`include "dedup_vertex_refcount_allocator_unit_assert.svh"
module dedup_vertex_refcount_allocator_unit
    import dva_pkg::*;
#(
    parameter int TRI_DEPTH  = TriDepthDef,
    parameter int VERT_DEPTH = VertDepthDef,
    parameter int MAX_REFS   = MaxRefsDef
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dva_in_t  s_data,
    input  logic     m_ready,
    output logic     m_valid,
    output dva_out_t m_data
);
    localparam int TW = $clog2(TRI_DEPTH);
    localparam int VW = $clog2(VERT_DEPTH);
    localparam int RW = $clog2(MAX_REFS + 4);
    localparam int CW = TW + 1;
    localparam int VC = VW + 1;
    // refs memory word: live bit and count
    localparam int LW = RW + 1;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_SCAN   = 14'b00000000000100,
        S_SCANW  = 14'b00000000001000,
        S_ALLOC  = 14'b00000000010000,
        S_ALLOCW = 14'b00000000100000,
        S_REFRD  = 14'b00000001000000,
        S_REFCK  = 14'b00000010000000,
        S_COMMIT = 14'b00000100000000,
        S_TRI    = 14'b00001000000000,
        S_TRIW   = 14'b00010000000000,
        S_REMRD  = 14'b00100000000000,
        S_REMW   = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    dva_in_t in_reg, in_next;
    logic [1:0] cor_reg, cor_next;
    logic [VC-1:0] idx_reg, idx_next;
    logic [VW-1:0] slot_reg [3], slot_next [3];
    logic fresh_reg [3], fresh_next [3];
    logic [1:0] nnew_reg, nnew_next;
    logic [CW-1:0] tfree_reg, tfree_next, thw_reg, thw_next;
    logic [VC-1:0] vfree_reg, vfree_next, vhw_reg, vhw_next;
    logic [2:0] st_reg, st_next;
    logic [TW-1:0] tslot_reg, tslot_next;
    logic rd_pend_reg, rd_pend_next;
    logic [VW-1:0] rd_addr_reg, rd_addr_next;
    logic [TRI_DEPTH-1:0] tlive_reg, tlive_next;
    logic out_valid_reg, out_valid_next;
    dva_out_t out_reg, out_next;

    // memories
    logic kwe, lwe, tcwe, tfwe, vfwe;
    logic [VW-1:0] kwa, kra, lwa, lra, vfwa, vfra;
    logic [95:0] kwd, krd;
    logic [LW-1:0] lwd, lrd;
    logic [TW-1:0] tcwa, tcra, tfwa, tfra;
    logic [3*VW-1:0] tcwd, tcrd;
    logic [TW-1:0] tfwd, tfrd;
    logic [VW-1:0] vfwd, vfrd;

    dva_ram #(.WIDTH(96), .DEPTH(VERT_DEPTH)) u_key (
        .aclk, .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(krd));
    dva_ram #(.WIDTH(LW), .DEPTH(VERT_DEPTH)) u_refs (
        .aclk, .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd));
    dva_ram #(.WIDTH(3*VW), .DEPTH(TRI_DEPTH)) u_corner (
        .aclk, .we(tcwe), .waddr(tcwa), .wdata(tcwd), .raddr(tcra), .rdata(tcrd));
    dva_ram #(.WIDTH(TW), .DEPTH(TRI_DEPTH)) u_tfree (
        .aclk, .we(tfwe), .waddr(tfwa), .wdata(tfwd), .raddr(tfra), .rdata(tfrd));
    dva_ram #(.WIDTH(VW), .DEPTH(VERT_DEPTH)) u_vfree (
        .aclk, .we(vfwe), .waddr(vfwa), .wdata(vfwd), .raddr(vfra), .rdata(vfrd));

    logic [95:0] key [3];
    assign key[0] = {in_reg.a_x, in_reg.a_y, in_reg.a_z};
    assign key[1] = {in_reg.b_x, in_reg.b_y, in_reg.b_z};
    assign key[2] = {in_reg.c_x, in_reg.c_y, in_reg.c_z};

    logic [VW-1:0] rslot;
    logic [RW-1:0] rcnt;
    logic [1:0] mult;
    logic [RW+1:0] tot;
    logic [1:0] dup_of;
    logic dup;
    logic [VC-1:0] avail;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        in_next = in_reg;
        cor_next = cor_reg;
        idx_next = idx_reg;
        slot_next = slot_reg;
        fresh_next = fresh_reg;
        nnew_next = nnew_reg;
        tfree_next = tfree_reg;
        thw_next = thw_reg;
        vfree_next = vfree_reg;
        vhw_next = vhw_reg;
        st_next = st_reg;
        tslot_next = tslot_reg;
        rd_pend_next = 1'b0;
        rd_addr_next = rd_addr_reg;
        tlive_next = tlive_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next = out_reg;
        kwe = 1'b0; kwa = slot_reg[cor_reg]; kwd = key[cor_reg];
        kra = idx_reg[VW-1:0];
        lwe = 1'b0; lwa = idx_reg[VW-1:0]; lwd = '0;
        lra = slot_reg[cor_reg];
        tcwe = 1'b0; tcwa = tslot_reg;
        tcwd = {slot_reg[0], slot_reg[1], slot_reg[2]};
        tcra = TW'(in_reg.remove_index);
        tfwe = 1'b0; tfwa = tfree_reg[TW-1:0]; tfwd = tslot_reg;
        tfra = tfree_reg[TW-1:0] - 1'b1;
        vfwe = 1'b0; vfwa = vfree_reg[VW-1:0]; vfwd = slot_reg[cor_reg];
        vfra = vfree_reg[VW-1:0] - VW'(nnew_reg) - 1'b1;
        rslot = slot_reg[cor_reg];
        rcnt = lrd[RW-1:0];
        mult = 2'd0;
        tot = '0;
        dup = 1'b0;
        dup_of = 2'd0;
        avail = vfree_reg + (VC'(VERT_DEPTH) - vhw_reg);
        for (int j = 0; j < 3; j++) begin
            if (j < 32'(cor_reg) && !dup && key[j] == key[cor_reg]) begin
                dup = 1'b1;
                dup_of = 2'(j);
            end
        end

        unique case (state_reg)
            S_CLEAR: begin
                lwe = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == VC'(VERT_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    in_next = s_data;
                    cor_next = 2'd0;
                    idx_next = '0;
                    nnew_next = 2'd0;
                    if (s_data.cmd == CMD_REMOVE) begin
                        if (32'(s_data.remove_index) >= TRI_DEPTH
                            || !tlive_reg[TW'(s_data.remove_index)]) begin
                            st_next = ST_BAD_INDEX;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_REMRD;
                        end
                    end else if (tfree_reg == '0 && thw_reg == CW'(TRI_DEPTH)) begin
                        st_next = ST_TRI_FULL;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            // issue key and live reads for slot idx, or reuse the slot of an earlier equal corner
            S_SCAN: begin
                if (dup) begin
                    slot_next[cor_reg] = slot_reg[dup_of];
                    fresh_next[cor_reg] = fresh_reg[dup_of];
                    state_next = S_ALLOCW;
                end else begin
                    kra = idx_reg[VW-1:0];
                    lra = idx_reg[VW-1:0];
                    rd_addr_next = idx_reg[VW-1:0];
                    state_next = S_SCANW;
                end
            end
            S_SCANW: begin
                if (lrd[RW] && krd == key[cor_reg]) begin
                    slot_next[cor_reg] = rd_addr_reg;
                    fresh_next[cor_reg] = 1'b0;
                    state_next = S_ALLOCW;
                end else if (idx_reg == VC'(VERT_DEPTH - 1)) begin
                    state_next = S_ALLOC;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            // free stack read issued here unless the vertex table is full, result picked next cycle
            S_ALLOC: begin
                if (VC'(nnew_reg) >= avail) begin
                    st_next = ST_VERT_FULL;
                    state_next = S_DONE;
                end else begin
                    rd_pend_next = 1'b1;
                    fresh_next[cor_reg] = 1'b1;
                    state_next = S_ALLOCW;
                end
            end
            S_ALLOCW: begin
                if (rd_pend_reg) begin
                    if (VC'(nnew_reg) < vfree_reg) begin
                        slot_next[cor_reg] = vfrd;
                    end else begin
                        slot_next[cor_reg] = VW'(vhw_reg + VC'(nnew_reg) - vfree_reg);
                    end
                    nnew_next = nnew_reg + 1'b1;
                end
                idx_next = '0;
                if (cor_reg == 2'd2) begin
                    cor_next = 2'd0;
                    state_next = S_REFRD;
                end else begin
                    cor_next = cor_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_REFRD: begin
                lra = slot_reg[cor_reg];
                state_next = S_REFCK;
            end
            S_REFCK: begin
                for (int j = 0; j < 3; j++) begin
                    if (slot_reg[j] == rslot) mult = mult + 1'b1;
                end
                tot = (fresh_reg[cor_reg] ? '0 : (RW+2)'(rcnt)) + (RW+2)'(mult);
                if (32'(tot) > MAX_REFS) begin
                    st_next = ST_OVERFLOW;
                    state_next = S_DONE;
                end else if (cor_reg == 2'd2) begin
                    cor_next = 2'd0;
                    state_next = S_COMMIT;
                end else begin
                    cor_next = cor_reg + 1'b1;
                    state_next = S_REFRD;
                end
            end
            // one corner per pass: read refs, then write back
            S_COMMIT: begin
                lra = slot_reg[cor_reg];
                rd_pend_next = 1'b1;
                if (rd_pend_reg) begin
                    lwe = 1'b1;
                    lwa = rslot;
                    lwd = {1'b1, rcnt + 1'b1};
                    if (fresh_reg[cor_reg] && !lrd[RW]) begin
                        lwd = {1'b1, RW'(1)};
                        kwe = 1'b1;
                    end
                    rd_pend_next = 1'b0;
                    if (cor_reg == 2'd2) begin
                        cor_next = 2'd0;
                        vfree_next = vfree_reg - ((VC'(nnew_reg) < vfree_reg) ?
                            VC'(nnew_reg) : vfree_reg);
                        vhw_next = vhw_reg + VC'(nnew_reg) - ((VC'(nnew_reg) < vfree_reg) ?
                            VC'(nnew_reg) : vfree_reg);
                        state_next = S_TRI;
                    end else begin
                        cor_next = cor_reg + 1'b1;
                    end
                end
            end
            S_TRI: begin
                tfra = tfree_reg[TW-1:0] - 1'b1;
                state_next = S_TRIW;
            end
            S_TRIW: begin
                if (tfree_reg != '0) begin
                    tslot_next = tfrd;
                    tfree_next = tfree_reg - 1'b1;
                end else begin
                    tslot_next = thw_reg[TW-1:0];
                    thw_next = thw_reg + 1'b1;
                end
                tcwe = 1'b1;
                tcwa = (tfree_reg != '0) ? tfrd : thw_reg[TW-1:0];
                tlive_next[tcwa] = 1'b1;
                st_next = ST_OK;
                state_next = S_DONE;
            end
            S_REMRD: begin
                tslot_next = TW'(in_reg.remove_index);
                {slot_next[0], slot_next[1], slot_next[2]} = tcrd;
                if (rd_pend_reg) begin
                    cor_next = 2'd0;
                    state_next = S_REMW;
                end
                rd_pend_next = 1'b1;
                if (rd_pend_reg) rd_pend_next = 1'b0;
            end
            // per corner: read refs, then decrement
            S_REMW: begin
                lra = slot_reg[cor_reg];
                rd_pend_next = !rd_pend_reg;
                if (rd_pend_reg) begin
                    if (rcnt != '0) begin
                        lwe = 1'b1;
                        lwa = rslot;
                        lwd = {(rcnt != RW'(1)), rcnt - 1'b1};
                        if (rcnt == RW'(1) && vfree_reg < VC'(VERT_DEPTH)) begin
                            vfwe = 1'b1;
                            vfwa = vfree_reg[VW-1:0];
                            vfwd = rslot;
                            vfree_next = vfree_reg + 1'b1;
                        end
                    end
                    if (cor_reg == 2'd2) begin
                        tlive_next[tslot_reg] = 1'b0;
                        if (tfree_reg < CW'(TRI_DEPTH)) begin
                            tfwe = 1'b1;
                            tfree_next = tfree_reg + 1'b1;
                        end
                        st_next = ST_OK;
                        state_next = S_DONE;
                    end else begin
                        cor_next = cor_reg + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_next.status = st_reg;
                    if (st_reg == ST_OK) begin
                        out_next.tri_slot = 8'(tslot_reg);
                        out_next.slot_a = 8'(slot_reg[0]);
                        out_next.slot_b = 8'(slot_reg[1]);
                        out_next.slot_c = 8'(slot_reg[2]);
                    end else begin
                        out_next.tri_slot = '0;
                        out_next.slot_a = '0;
                        out_next.slot_b = '0;
                        out_next.slot_c = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            tfree_reg <= '0;
            thw_reg <= '0;
            vfree_reg <= '0;
            vhw_reg <= '0;
            tlive_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            tfree_reg <= tfree_next;
            thw_reg <= thw_next;
            vfree_reg <= vfree_next;
            vhw_reg <= vhw_next;
            tlive_reg <= tlive_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg <= rd_pend_next;
        end
        in_reg <= in_next;
        cor_reg <= cor_next;
        slot_reg <= slot_next;
        fresh_reg <= fresh_next;
        nnew_reg <= nnew_next;
        st_reg <= st_next;
        tslot_reg <= tslot_next;
        rd_addr_reg <= rd_addr_next;
        out_reg <= out_next;
    end

    `DVA_ASSERT_NEVER(a_tri_hw, aclk, aresetn, thw_reg > CW'(TRI_DEPTH), "tri high water")
    `DVA_ASSERT_NEVER(a_vert_hw, aclk, aresetn, vhw_reg > VC'(VERT_DEPTH), "vert high water")
    `DVA_ASSERT_IMPL(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped")
endmodule

>>> test/tb_dedup_vertex_refcount_allocator_unit.sv
// Self-checking testbench for the dedup vertex allocator unit.
// Drives random add/remove items and compares each result with an in-bench predictor.
// Depends on dva_pkg and dedup_vertex_refcount_allocator_unit.
module tb_dedup_vertex_refcount_allocator_unit
    import dva_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTRI  = TriDepthDef;
    localparam int NVERT = VertDepthDef;
    localparam int NREFS = MaxRefsDef;

    // Predictor of the triangle and vertex tables; holds expected results in order.
    class alloc_scoreboard;
        logic [7:0]  tri_corner [NTRI][3];
        bit          tri_live   [NTRI];
        logic [7:0]  tri_stack  [NTRI];
        int          tri_top, tri_hw;
        logic [95:0] vkey   [NVERT];
        bit          vlive  [NVERT];
        int          vrefs  [NVERT];
        logic [7:0]  vstack [NVERT];
        int          vtop, vhw;
        dva_out_t    pending[$];
        int          errors;

        function void clear();
            tri_top = 0; tri_hw = 0; vtop = 0; vhw = 0; errors = 0;
            foreach (tri_live[i]) tri_live[i] = 0;
            foreach (vlive[i]) begin
                vlive[i] = 0;
                vrefs[i] = 0;
            end
        endfunction

        function int lookup(logic [95:0] k);
            for (int i = 0; i < NVERT; i++)
                if (vlive[i] && vkey[i] == k) return i;
            return -1;
        endfunction

        function void release_vert(int s);
            if (vrefs[s] == 0) return;
            vrefs[s]--;
            if (vrefs[s] == 0) begin
                vlive[s] = 0;
                if (vtop < NVERT) begin
                    vstack[vtop] = 8'(s);
                    vtop++;
                end
            end
        endfunction

        function dva_out_t compute(dva_in_t it);
            dva_out_t r;
            logic [95:0] k[3];
            int slot[3];
            bit fresh[3];
            int nnew, avail, f, m, base, t, take;
            bit shared;
            r = '0;
            if (it.cmd == CMD_REMOVE) begin
                t = int'(it.remove_index);
                if (t >= NTRI || !tri_live[t]) begin
                    r.status = ST_BAD_INDEX;
                    return r;
                end
                for (int i = 0; i < 3; i++) slot[i] = int'(tri_corner[t][i]);
                for (int i = 0; i < 3; i++) release_vert(slot[i]);
                tri_live[t] = 0;
                if (tri_top < NTRI) begin
                    tri_stack[tri_top] = 8'(t);
                    tri_top++;
                end
                r.status = ST_OK; r.tri_slot = 8'(t);
                r.slot_a = 8'(slot[0]); r.slot_b = 8'(slot[1]); r.slot_c = 8'(slot[2]);
                return r;
            end
            if (tri_top == 0 && tri_hw >= NTRI) begin
                r.status = ST_TRI_FULL;
                return r;
            end
            k[0] = {it.a_x, it.a_y, it.a_z};
            k[1] = {it.b_x, it.b_y, it.b_z};
            k[2] = {it.c_x, it.c_y, it.c_z};
            nnew = 0;
            avail = vtop + (NVERT - vhw);
            for (int i = 0; i < 3; i++) begin
                shared = 0;
                for (int j = 0; j < i; j++)
                    if (!shared && k[j] == k[i]) begin
                        slot[i] = slot[j]; fresh[i] = fresh[j]; shared = 1;
                    end
                if (!shared) begin
                    f = lookup(k[i]);
                    if (f >= 0) begin
                        slot[i] = f; fresh[i] = 0;
                    end else begin
                        if (nnew >= avail) begin
                            r.status = ST_VERT_FULL;
                            return r;
                        end
                        slot[i] = (nnew < vtop) ? int'(vstack[vtop - 1 - nnew])
                                                : vhw + (nnew - vtop);
                        fresh[i] = 1;
                        nnew++;
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                m = 0;
                for (int j = 0; j < 3; j++) if (slot[j] == slot[i]) m++;
                base = fresh[i] ? 0 : vrefs[slot[i]];
                if (base + m > NREFS) begin
                    r.status = ST_OVERFLOW;
                    return r;
                end
            end
            take = (nnew < vtop) ? nnew : vtop;
            vtop -= take;
            vhw += nnew - take;
            for (int i = 0; i < 3; i++) begin
                if (fresh[i] && !vlive[slot[i]]) begin
                    vkey[slot[i]] = k[i]; vlive[slot[i]] = 1; vrefs[slot[i]] = 0;
                end
                vrefs[slot[i]]++;
            end
            if (tri_top > 0) begin
                tri_top--;
                t = int'(tri_stack[tri_top]);
            end else begin
                t = tri_hw;
                tri_hw++;
            end
            for (int i = 0; i < 3; i++) tri_corner[t][i] = 8'(slot[i]);
            tri_live[t] = 1;
            r.status = ST_OK; r.tri_slot = 8'(t);
            r.slot_a = 8'(slot[0]); r.slot_b = 8'(slot[1]); r.slot_c = 8'(slot[2]);
            return r;
        endfunction

        function void note_input(dva_in_t it);
            pending = {pending, compute(it)};
        endfunction

        function void check_result(dva_out_t got);
            dva_out_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status || got.tri_slot !== exp_r.tri_slot ||
                got.slot_a !== exp_r.slot_a || got.slot_b !== exp_r.slot_b ||
                got.slot_c !== exp_r.slot_c) begin
                $display("%0t: exp st=%0d t=%0d v=%0d/%0d/%0d got st=%0d t=%0d v=%0d/%0d/%0d",
                         $realtime, exp_r.status, exp_r.tri_slot, exp_r.slot_a, exp_r.slot_b,
                         exp_r.slot_c, got.status, got.tri_slot, got.slot_a, got.slot_b,
                         got.slot_c);
                errors++;
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    dva_in_t  s_data;
    logic     m_ready;
    logic     m_valid;
    dva_out_t m_data;

    alloc_scoreboard sb;
    logic [95:0] key_pool[16];
    bit          hold_sink;

    dedup_vertex_refcount_allocator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_ready(m_ready), .m_valid(m_valid), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one item and hold it until the block takes it; drop valid only for a gap.
    task automatic send_item(dva_in_t it);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    function automatic dva_in_t make_add(logic [95:0] ka, logic [95:0] kb, logic [95:0] kc);
        dva_in_t it;
        it = '0;
        it.cmd = CMD_ADD;
        it.remove_index = 8'($urandom);
        {it.a_x, it.a_y, it.a_z} = ka;
        {it.b_x, it.b_y, it.b_z} = kb;
        {it.c_x, it.c_y, it.c_z} = kc;
        return it;
    endfunction

    function automatic dva_in_t make_remove(logic [7:0] idx);
        dva_in_t it;
        it = '0;
        it.cmd = CMD_REMOVE;
        it.remove_index = idx;
        {it.a_x, it.a_y, it.a_z, it.b_x, it.b_y, it.b_z, it.c_x, it.c_y, it.c_z} =
            {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
        return it;
    endfunction

    function automatic logic [95:0] rand_key();
        return {$urandom, $urandom, $urandom};
    endfunction

    // Draw from a small pool so vertices repeat and get shared.
    function automatic logic [95:0] pool_key();
        if ($urandom_range(0, 4) == 0) return rand_key();
        return key_pool[$urandom_range(0, 15)];
    endfunction

    function automatic logic [7:0] live_tri();
        int live[$];
        for (int i = 0; i < NTRI; i++) if (sb.tri_live[i]) live = {live, i};
        if (live.size() == 0) return 8'($urandom);
        return 8'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    // Result side: random stalls, with one long hold while the sender keeps going.
    initial begin
        int g;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_sink = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    initial begin
        logic [95:0] kx, ky;
        int wait_cnt;
        sb = new();
        sb.clear();
        foreach (key_pool[i]) key_pool[i] = rand_key();
        key_pool[0] = '0;
        key_pool[1] = '1;
        hold_sink = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: remove of a dead slot, extremes, shared corners, overflow.
        send_item(make_remove(8'd0));
        send_item(make_remove(8'd255));
        send_item(make_add('0, '1, 96'h0000_0001_8000_0000_7f80_0000));
        send_item(make_add('1, '1, '1));
        send_item(make_add('0, '0, '1));
        send_item(make_remove(8'd0));
        send_item(make_remove(8'd0));
        send_item(make_remove(8'd1));
        kx = rand_key();
        ky = rand_key();
        for (int i = 0; i < 86; i++) send_item(make_add(kx, kx, kx));
        send_item(make_remove(8'd3));
        send_item(make_add(kx, ky, kx));
        send_item(make_add(kx, ky, ky));

        // Long hold on the result side so the block back-pressures the input.
        hold_sink = 1;
        for (int i = 0; i < 8; i++) send_item(make_add(pool_key(), pool_key(), rand_key()));

        // Clear the triangle table before the fill phase.
        for (int t = 0; t < NTRI; t++)
            if (sb.tri_live[t]) send_item(make_remove(8'(t)));

        // Fill the vertex table to the top, then hit the vertex-full case.
        for (int i = 0; i < 90; i++) send_item(make_add(rand_key(), rand_key(), rand_key()));
        send_item(make_add(rand_key(), key_pool[2], key_pool[3]));
        for (int i = 0; i < 170; i++)
            send_item(make_add(key_pool[2], key_pool[3], ($urandom_range(0, 1)) ?
                               key_pool[4] : key_pool[5]));
        for (int i = 0; i < 6; i++) send_item(make_add(rand_key(), rand_key(), rand_key()));
        for (int t = 0; t < NTRI; t++)
            if (sb.tri_live[t]) send_item(make_remove(8'(t)));

        // Random mix of shared-vertex adds and removes.
        for (int i = 0; i < 600; i++) begin
            if ($urandom_range(0, 99) < 55)
                send_item(make_add(pool_key(), pool_key(), pool_key()));
            else if ($urandom_range(0, 9) == 0)
                send_item(make_remove(8'($urandom)));
            else
                send_item(make_remove(live_tri()));
        end
        s_valid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 200000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (1000) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> dedup_vertex_refcount_allocator_unit.f
+incdir+hw/rtl
hw/rtl/dva_pkg.sv
hw/rtl/dva_ram.sv
hw/rtl/dedup_vertex_refcount_allocator_unit.sv
test/tb_dedup_vertex_refcount_allocator_unit.sv
